>>> src/btpc_pkg.sv
// shared types, widths and register codes for the barometer compensation pipeline
package btpc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEFF_W = 16;
    localparam int TEMP_W  = 19;
    localparam int PRES_W  = 32;
    localparam int CFG_IDX_W = 3;

    localparam int DT_W   = 25;   // raw temperature minus reference
    localparam int TPR_W  = 42;   // dt times a coefficient
    localparam int DSQ_W  = 49;   // dt squared, non-negative
    localparam int T2_W   = 18;   // dt squared shifted down by 31
    localparam int SQ_W   = 36;   // squared temperature deviation
    localparam int OS_W   = 40;   // offset and sensitivity
    localparam int PL_W   = 44;   // raw pressure times low sensitivity half
    localparam int PH_W   = 45;   // raw pressure times high sensitivity half
    localparam int PROD_W = 64;
    localparam int Q_W    = 45;

    localparam int SPLIT  = 20;   // sensitivity split point for the partial products
    localparam int STAGES = 10;

    localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW = 19'sd3500;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_SENS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_OFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SENS_TEMP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TEMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_TEMP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_GAIN   = 3'd5;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } t_in;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic signed [PRES_W-1:0] pressure;
        logic                     second_order_used;
        logic                     very_low_temp;
    } t_out;

endpackage

>>> src/baro_temp_pressure_compensation.sv
// second-order barometer temperature and pressure compensation pipeline
// throughput: one item per cycle while output is ready; a stage holds while its successor
// is full and stalled, so bubbles squeeze out and input is taken until the pipe is full
// widest path per stage is one 25x25 multiply or one 64-bit add
// reset clears all stage valid bits and the six calibration words to zero
module baro_temp_pressure_compensation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  btpc_pkg::t_in                     i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output btpc_pkg::t_out                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [btpc_pkg::COEFF_W-1:0]      i_cfg_data
);
    import btpc_pkg::*;

    // calibration words
    logic [COEFF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    logic [STAGES-1:0] r_v;
    logic [STAGES:0]   w_rdy;

    // stage registers
    logic signed [DT_W-1:0]   r1_dt;
    logic [RAW_W-1:0]         r1_d1;

    logic signed [TPR_W-1:0]  r2_pt, r2_po, r2_ps;
    logic [DSQ_W-1:0]         r2_dsq;
    logic [RAW_W-1:0]         r2_d1;

    logic signed [TEMP_W-1:0] r3_a, r3_b, r3_temp;
    logic [T2_W-1:0]          r3_t2;
    logic                     r3_low, r3_vlow;
    logic signed [OS_W-1:0]   r3_off, r3_sens;
    logic [RAW_W-1:0]         r3_d1;

    logic [SQ_W-1:0]          r4_sq, r4_sq2;
    logic signed [TEMP_W-1:0] r4_temp;
    logic                     r4_low, r4_vlow;
    logic signed [OS_W-1:0]   r4_off, r4_sens;
    logic [RAW_W-1:0]         r4_d1;

    logic [OS_W-1:0]          r5_off2, r5_sens2;
    logic signed [TEMP_W-1:0] r5_temp;
    logic                     r5_low, r5_vlow;
    logic signed [OS_W-1:0]   r5_off, r5_sens;
    logic [RAW_W-1:0]         r5_d1;

    logic signed [TEMP_W-1:0] r6_temp;
    logic                     r6_low, r6_vlow;
    logic signed [OS_W-1:0]   r6_off, r6_sens;
    logic [RAW_W-1:0]         r6_d1;

    logic [PL_W-1:0]          r7_pl;
    logic signed [PH_W-1:0]   r7_ph;
    logic signed [TEMP_W-1:0] r7_temp;
    logic                     r7_low, r7_vlow;
    logic signed [OS_W-1:0]   r7_off;

    logic signed [PROD_W-1:0] r8_prod;
    logic signed [TEMP_W-1:0] r8_temp;
    logic                     r8_low, r8_vlow;
    logic signed [OS_W-1:0]   r8_off;

    logic signed [Q_W-1:0]    r9_q;
    logic signed [TEMP_W-1:0] r9_temp;
    logic                     r9_low, r9_vlow;

    t_out                     r_out;

    // combinational stage logic
    logic signed [DT_W-1:0]   w_dt;
    logic signed [TPR_W-1:0]  w_pt, w_po, w_ps;
    logic signed [2*DT_W-1:0] w_dsq;
    logic signed [TEMP_W-1:0] w_a;
    logic signed [TPR_W-8:0]  w_po_sh;
    logic signed [TPR_W-9:0]  w_ps_sh;
    logic signed [OS_W-1:0]   w_off1, w_sens1;
    logic signed [2*TEMP_W-1:0] w_asq, w_bsq;
    logic signed [TEMP_W-1:0] w_temp4;
    logic [OS_W-1:0]          w_e, w_e2, w_five, w_seven, w_eleven, w_off2, w_sens2;
    logic [PL_W-1:0]          w_pl;
    logic signed [PH_W-1:0]   w_ph;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-22:0] w_prod_sh;
    logic signed [Q_W-1:0]    w_q;
    t_out                     w_out;

    // each stage may load when empty or when the next stage is moving
    always_comb begin
        w_rdy[STAGES] = i_out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_v[STAGES-1];
    assign o_out_data  = r_out;

    always_comb begin
        w_dt = $signed({1'b0, i_in_data.raw_temperature}) - $signed({1'b0, r_c5, 8'd0});

        w_pt  = r1_dt * $signed({1'b0, r_c6});
        w_po  = r1_dt * $signed({1'b0, r_c4});
        w_ps  = r1_dt * $signed({1'b0, r_c3});
        w_dsq = r1_dt * r1_dt;

        // floor shift by 23 is the upper bits of the product
        w_a     = $signed(r2_pt[TPR_W-1:23]);
        w_po_sh = $signed(r2_po[TPR_W-1:7]);
        w_ps_sh = $signed(r2_ps[TPR_W-1:8]);
        w_off1  = $signed({8'd0, r_c2, 16'd0}) + OS_W'(w_po_sh);
        w_sens1 = $signed({9'd0, r_c1, 15'd0}) + OS_W'(w_ps_sh);

        w_asq   = r3_a * r3_a;
        w_bsq   = r3_b * r3_b;
        w_temp4 = r3_low ? (r3_temp - $signed({1'b0, r3_t2})) : r3_temp;

        w_e      = {{(OS_W-SQ_W){1'b0}}, r4_sq};
        w_e2     = {{(OS_W-SQ_W){1'b0}}, r4_sq2};
        w_five   = (w_e << 2) + w_e;
        w_seven  = (w_e2 << 3) - w_e2;
        w_eleven = (w_e2 << 3) + (w_e2 << 1) + w_e2;
        w_off2   = '0;
        w_sens2  = '0;
        if (r4_low) begin
            w_off2  = (w_five >> 1) + (r4_vlow ? w_seven : '0);
            w_sens2 = (w_five >> 2) + (r4_vlow ? (w_eleven >> 1) : '0);
        end

        // sensitivity split into an unsigned low half and a signed high half
        w_pl = PL_W'(r6_d1) * PL_W'(r6_sens[SPLIT-1:0]);
        w_ph = $signed({1'b0, r6_d1}) * $signed(r6_sens[OS_W-1:SPLIT]);

        w_prod = (PROD_W'(r7_ph) <<< SPLIT) + $signed({{(PROD_W-PL_W){1'b0}}, r7_pl});

        w_prod_sh = $signed(r8_prod[PROD_W-1:21]);
        w_q       = Q_W'(w_prod_sh) - Q_W'(r8_off);

        // shifted result spans 30 bits, so the 32-bit clamp never engages
        w_out.temperature       = r9_temp;
        w_out.pressure          = PRES_W'($signed(r9_q[Q_W-1:15]));
        w_out.second_order_used = r9_low;
        w_out.very_low_temp     = r9_vlow;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRESS_SENS: r_c1 <= i_cfg_data;
                    CFG_PRESS_OFF:  r_c2 <= i_cfg_data;
                    CFG_SENS_TEMP:  r_c3 <= i_cfg_data;
                    CFG_OFF_TEMP:   r_c4 <= i_cfg_data;
                    CFG_REF_TEMP:   r_c5 <= i_cfg_data;
                    CFG_TEMP_GAIN:  r_c6 <= i_cfg_data;
                    default: ;
                endcase
            end
            for (int k = 0; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= (k == 0) ? i_in_valid : r_v[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r1_dt <= w_dt;
            r1_d1 <= i_in_data.raw_pressure;
        end
        if (w_rdy[1]) begin
            r2_pt  <= w_pt;
            r2_po  <= w_po;
            r2_ps  <= w_ps;
            r2_dsq <= w_dsq[DSQ_W-1:0];
            r2_d1  <= r1_d1;
        end
        if (w_rdy[2]) begin
            r3_a    <= w_a;
            r3_b    <= w_a + TEMP_VLOW;
            r3_temp <= w_a + TEMP_REF;
            r3_t2   <= r2_dsq[DSQ_W-1:31];
            r3_low  <= r2_pt[TPR_W-1];
            r3_vlow <= w_a < -TEMP_VLOW;
            r3_off  <= w_off1;
            r3_sens <= w_sens1;
            r3_d1   <= r2_d1;
        end
        if (w_rdy[3]) begin
            r4_sq   <= w_asq[SQ_W-1:0];
            r4_sq2  <= w_bsq[SQ_W-1:0];
            r4_temp <= w_temp4;
            r4_low  <= r3_low;
            r4_vlow <= r3_vlow;
            r4_off  <= r3_off;
            r4_sens <= r3_sens;
            r4_d1   <= r3_d1;
        end
        if (w_rdy[4]) begin
            r5_off2  <= w_off2;
            r5_sens2 <= w_sens2;
            r5_temp  <= r4_temp;
            r5_low   <= r4_low;
            r5_vlow  <= r4_vlow;
            r5_off   <= r4_off;
            r5_sens  <= r4_sens;
            r5_d1    <= r4_d1;
        end
        if (w_rdy[5]) begin
            r6_off  <= r5_off - $signed(r5_off2);
            r6_sens <= r5_sens - $signed(r5_sens2);
            r6_temp <= r5_temp;
            r6_low  <= r5_low;
            r6_vlow <= r5_vlow;
            r6_d1   <= r5_d1;
        end
        if (w_rdy[6]) begin
            r7_pl   <= w_pl;
            r7_ph   <= w_ph;
            r7_temp <= r6_temp;
            r7_low  <= r6_low;
            r7_vlow <= r6_vlow;
            r7_off  <= r6_off;
        end
        if (w_rdy[7]) begin
            r8_prod <= w_prod;
            r8_temp <= r7_temp;
            r8_low  <= r7_low;
            r8_vlow <= r7_vlow;
            r8_off  <= r7_off;
        end
        if (w_rdy[8]) begin
            r9_q    <= w_q;
            r9_temp <= r8_temp;
            r9_low  <= r8_low;
            r9_vlow <= r8_vlow;
        end
        if (w_rdy[9]) begin
            r_out <= w_out;
        end
    end

endmodule

>>> tb/btpc_comp_checker.sv
// checker for the barometer compensation pipeline: predicts each result and compares it
module btpc_comp_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  btpc_pkg::t_in                  i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  btpc_pkg::t_out                 i_out_data,
    input  logic                           i_cfg_we,
    input  logic [btpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [btpc_pkg::COEFF_W-1:0]   i_cfg_data,
    output int                             o_pending,
    output int                             o_errors
);
    import btpc_pkg::*;

    localparam longint PRES_MAX = 64'sd2147483647;
    localparam longint PRES_MIN = -PRES_MAX - 1;

    logic [COEFF_W-1:0] sens_word;
    logic [COEFF_W-1:0] off_word;
    logic [COEFF_W-1:0] sens_tc;
    logic [COEFF_W-1:0] off_tc;
    logic [COEFF_W-1:0] tref_word;
    logic [COEFF_W-1:0] tgain_word;

    t_out pending_results [$];
    int   mismatches = 0;

    assign o_errors = mismatches;

    // compensated temperature and pressure for one raw sample at the current calibration
    function automatic t_out compensate(input t_in smp);
        longint d1, d2, c1, c2, c3, c4, c5, c6;
        longint dt, temp, off, sens, t2, off2, sens2, dev, sq, pres;
        logic   low, vlow;
        t_out   r;
        d1 = {40'd0, smp.raw_pressure};
        d2 = {40'd0, smp.raw_temperature};
        c1 = {48'd0, sens_word};
        c2 = {48'd0, off_word};
        c3 = {48'd0, sens_tc};
        c4 = {48'd0, off_tc};
        c5 = {48'd0, tref_word};
        c6 = {48'd0, tgain_word};

        dt   = d2 - c5 * 256;
        temp = 2000 + ((dt * c6) >>> 23);
        off  = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        low  = temp < 2000;
        vlow = temp < -1500;
        t2    = 0;
        off2  = 0;
        sens2 = 0;
        if (low) begin
            dev   = temp - 2000;
            sq    = dev * dev;
            t2    = (dt * dt) >>> 31;
            off2  = (5 * sq) >>> 1;
            sens2 = (5 * sq) >>> 2;
            if (vlow) begin
                dev   = temp + 1500;
                sq    = dev * dev;
                off2  = off2 + 7 * sq;
                sens2 = sens2 + ((11 * sq) >>> 1);
            end
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;

        pres = (((d1 * sens) >>> 21) - off) >>> 15;
        if (pres > PRES_MAX) pres = PRES_MAX;
        if (pres < PRES_MIN) pres = PRES_MIN;

        r.temperature       = temp[TEMP_W-1:0];
        r.pressure          = pres[PRES_W-1:0];
        r.second_order_used = low;
        r.very_low_temp     = vlow;
        return r;
    endfunction

    task automatic flag_field(input string field, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        if (!i_rst_n) begin
            sens_word  = '0;
            off_word   = '0;
            sens_tc    = '0;
            off_tc     = '0;
            tref_word  = '0;
            tgain_word = '0;
            pending_results.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(compensate(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pending_results.size() == 0) begin
                    $display("%0t: result transfer with nothing expected, got temp %0d pres %0d",
                             $time, got.temperature, got.pressure);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.temperature !== want.temperature)
                        flag_field("temperature", want.temperature, got.temperature);
                    if (got.pressure !== want.pressure)
                        flag_field("pressure", want.pressure, got.pressure);
                    if (got.second_order_used !== want.second_order_used)
                        flag_field("second_order_used", want.second_order_used,
                                   got.second_order_used);
                    if (got.very_low_temp !== want.very_low_temp)
                        flag_field("very_low_temp", want.very_low_temp, got.very_low_temp);
                end
            end
            // the user lets config writes land only while the pipe is empty, unenforced
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PRESS_SENS: sens_word  = i_cfg_data;
                    CFG_PRESS_OFF:  off_word   = i_cfg_data;
                    CFG_SENS_TEMP:  sens_tc    = i_cfg_data;
                    CFG_OFF_TEMP:   off_tc     = i_cfg_data;
                    CFG_REF_TEMP:   tref_word  = i_cfg_data;
                    CFG_TEMP_GAIN:  tgain_word = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= pending_results.size();
    end

endmodule

>>> tb/baro_temp_pressure_compensation_test.sv
// testbench top for the barometer compensation pipeline: stimulus, pacing and verdict
module baro_temp_pressure_compensation_test;
    import btpc_pkg::*;

    localparam int RAW_MAX       = (1 << RAW_W) - 1;
    localparam int COEFF_MAX     = (1 << COEFF_W) - 1;
    localparam int REF_SPAN      = 1 << 21;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 50;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 2 * STAGES + 10;
    // directed calibration: gain of 2^15 makes the temperature step one count per 256 of dt
    localparam int DIR_REF       = 32768 * 256;
    localparam int VLOW_DT       = 3500 * 256;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_out                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [COEFF_W-1:0]   cfg_data  = '0;

    int   pending;
    int   errors;
    int   idle_cycles = 0;
    int   out_hold    = 0;
    logic calm_out    = 1'b0;
    logic calm_in     = 1'b0;

    logic [COEFF_W-1:0] cal [6];

    always #1 i_clk = ~i_clk;

    baro_temp_pressure_compensation u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    btpc_comp_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    // result side may hold ready low after each transfer, at random unless calm_out is set
    always @(posedge i_clk) begin
        int n;
        if (out_valid && out_ready) begin
            n = calm_out ? 0 : $urandom_range(0, 5);
            out_hold  <= n;
            out_ready <= (n == 0);
        end else if (out_hold != 0) begin
            out_hold  <= out_hold - 1;
            out_ready <= (out_hold == 1);
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("[baro_temp_pressure_compensation] ERROR");
        $finish;
    end

    task automatic send_sample(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid                <= 1'b1;
        in_data.raw_pressure    <= raw_p;
        in_data.raw_temperature <= raw_t;
        do @(posedge i_clk); while (!in_ready);
    endtask

    task automatic draw_sample();
        int ref_level, raw_t, raw_p;
        ref_level = int'(cal[CFG_REF_TEMP]) * 256;
        case ($urandom_range(0, 3))
            0: raw_t = $urandom_range(0, RAW_MAX);
            3: raw_t = $urandom_range(0, ref_level);
            default: raw_t = ref_level + $urandom_range(0, 2 * REF_SPAN) - REF_SPAN;
        endcase
        if (raw_t < 0) raw_t = 0;
        if (raw_t > RAW_MAX) raw_t = RAW_MAX;
        if ($urandom_range(0, 7) == 0)
            raw_p = $urandom_range(0, 1) ? RAW_MAX : 0;
        else
            raw_p = $urandom_range(0, RAW_MAX);
        send_sample(RAW_W'(raw_p), RAW_W'(raw_t));
    endtask

    // drop valid and wait until every expected result has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic put_word(input logic [CFG_IDX_W-1:0] idx);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= cal[idx];
        @(posedge i_clk);
    endtask

    task automatic apply_cal();
        put_word(CFG_PRESS_SENS);
        put_word(CFG_PRESS_OFF);
        put_word(CFG_SENS_TEMP);
        put_word(CFG_OFF_TEMP);
        put_word(CFG_REF_TEMP);
        put_word(CFG_TEMP_GAIN);
        // write to an unused index, must leave the calibration alone
        cfg_idx  <= $urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B;
        cfg_data <= COEFF_W'($urandom_range(0, COEFF_MAX));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [COEFF_W-1:0] draw_word();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? COEFF_W'(COEFF_MAX) : '0;
        return COEFF_W'($urandom_range(0, COEFF_MAX));
    endfunction

    initial begin
        int p, k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // calibration still at its reset value
        send_sample(0, 0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'h123456, 24'h800000);
        settle();

        cal[CFG_PRESS_SENS] = 16'd40127;
        cal[CFG_PRESS_OFF]  = 16'd36924;
        cal[CFG_SENS_TEMP]  = 16'd23317;
        cal[CFG_OFF_TEMP]   = 16'd23282;
        cal[CFG_REF_TEMP]   = 16'd32768;
        cal[CFG_TEMP_GAIN]  = 16'd32768;
        apply_cal();
        // first-order edge at 20.00 C and the extra term edge at -15.00 C
        send_sample(0, DIR_REF);
        send_sample(RAW_MAX, DIR_REF - 1);
        send_sample(24'h800000, DIR_REF - VLOW_DT);
        send_sample(24'h800000, DIR_REF - VLOW_DT - 1);
        send_sample(1, DIR_REF + 1);
        send_sample(RAW_MAX, 0);
        send_sample(0, 0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(0, RAW_MAX);
        send_sample(24'hAAAAAA, 24'h555555);
        send_sample(24'h555555, 24'hAAAAAA);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            for (k = 0; k < 6; k++) begin
                if (p == 0)
                    cal[k] = '0;
                else if (p == 1)
                    cal[k] = COEFF_MAX;
                else
                    cal[k] = draw_word();
            end
            if (p == 2) begin
                cal[CFG_PRESS_SENS] = 16'd40127;
                cal[CFG_PRESS_OFF]  = 16'd36924;
                cal[CFG_SENS_TEMP]  = 16'd23317;
                cal[CFG_OFF_TEMP]   = 16'd23282;
                cal[CFG_REF_TEMP]   = 16'd33464;
                cal[CFG_TEMP_GAIN]  = 16'd28312;
            end
            apply_cal();
            calm_in = ($urandom_range(0, 3) == 0);
            calm_out <= ($urandom_range(0, 3) == 0);
            for (k = 0; k < PHASE_ITEMS; k++)
                draw_sample();
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("[baro_temp_pressure_compensation] OK");
        else
            $display("[baro_temp_pressure_compensation] ERROR");
        $finish;
    end

endmodule

>>> sim.f
src/btpc_pkg.sv
src/baro_temp_pressure_compensation.sv
tb/btpc_comp_checker.sv
tb/baro_temp_pressure_compensation_test.sv
